FILE: rtl/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types, constants and arithmetic helpers for the vertex projector.
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                  // signed data word
    localparam int UW        = 31;                  // unsigned depth word
    localparam int PW        = 2 * DW - FRAC_BITS;  // shifted row product
    localparam int SW        = PW + 2;              // row sum
    localparam int MW        = 2 * DW;              // screen product register

    localparam logic [63:0] MAX31_W   = 64'h7FFF_FFFF;
    localparam logic [63:0] DIST_FULL = 64'd188 << FRAC_BITS;
    localparam logic [63:0] NEAR_FULL = DIST_FULL / 64'd32;
    localparam logic [UW-1:0] SD_RESET =
        UW'((DIST_FULL > MAX31_W) ? MAX31_W : DIST_FULL);
    localparam logic [UW-1:0] NEAR_RESET =
        UW'((NEAR_FULL > MAX31_W) ? MAX31_W : NEAR_FULL);
    localparam logic [UW-1:0] MAX31 = {UW{1'b1}};

    localparam logic [DW:0] SHADE_BIAS = (DW + 1)'((3 * (64'd1 << FRAC_BITS) + 5) / 10);

    // screen scale: 704 = 11 * 64, 448 = 7 * 64
    localparam int SCALE_SHIFT = FRAC_BITS + 6;
    localparam int RW          = 4;
    localparam logic [RW-1:0] ODD_X = RW'(11);
    localparam logic [RW-1:0] ODD_Y = RW'(7);
    localparam int QW      = MW - 2 - SCALE_SHIFT;
    localparam int LD_BITS = 8;
    localparam int LD_STG  = (QW + LD_BITS - 1) / LD_BITS;
    localparam int LDW     = LD_STG * LD_BITS;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        CFG_XA, CFG_XB, CFG_YA, CFG_YB, CFG_ZA, CFG_ZB, CFG_DIST, CFG_NEAR
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] xa;
        logic [63:0] xb;
        logic [63:0] ya;
        logic [63:0] yb;
        logic [63:0] za;
        logic [63:0] zb;
    } coef_t;

    typedef struct packed {
        logic signed [DW-1:0] tx;
        logic signed [DW-1:0] ty;
        logic [UW-1:0]        depth;
        logic                 clipped;
        logic signed [DW-1:0] shade;
        logic                 last;
    } view_t;

    typedef struct packed {
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic [UW-1:0]        depth;
        logic [UW-1:0]        inv;
        logic                 clipped;
        logic signed [DW-1:0] shade;
        logic                 last;
    } proj_t;

    function automatic logic signed [PW-1:0] prod_shift(input logic [DW-1:0] c,
                                                        input logic signed [DW-1:0] v);
        logic signed [2*DW-1:0] p;
        p = $signed(c) * v;
        return PW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] s);
        if (&s[SW-1:DW-1] || ~|s[SW-1:DW-1])
            return s[DW-1:0];
        else
            return s[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    // one chunk of long division by a small constant
    function automatic logic [LD_BITS+RW-1:0] ld_step(input logic [RW-1:0] r,
                                                      input logic [LD_BITS-1:0] chunk,
                                                      input logic [RW-1:0] d);
        logic [RW:0]        t;
        logic [RW-1:0]      rr;
        logic [LD_BITS-1:0] q;
        rr = r;
        q  = '0;
        for (int i = LD_BITS - 1; i >= 0; i--)
        begin
            t = {rr, chunk[i]};
            if (t >= {1'b0, d})
            begin
                t    = t - {1'b0, d};
                q[i] = 1'b1;
            end
            rr = t[RW-1:0];
        end
        return {q, rr};
    endfunction

endpackage

FILE: rtl/pvp_front.sv
// ----------------------------------------------------------------------------
// pvp_front
// Matrix transform, near-plane clamp and shade bias; feeds the view queue.
// ----------------------------------------------------------------------------
module pvp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            shade_in,
    input  logic                          last_vertex,
    input  pvp_pkg::coef_t                coef,
    input  logic [pvp_pkg::UW-1:0]        near_plane,
    output logic                          q_valid,
    output pvp_pkg::view_t                q_item,
    input  logic                          q_ready
);
    import pvp_pkg::*;

    logic                 en;
    logic                 s1_valid_reg, s1_valid_next;
    logic signed [PW-1:0] px_reg [3];
    logic signed [PW-1:0] py_reg [3];
    logic signed [PW-1:0] pz_reg [3];
    logic signed [DW-1:0] s1_shade_reg;
    logic                 s1_last_reg;
    logic                 s2_valid_reg, s2_valid_next;
    view_t                s2_item_reg, s2_item_next;
    logic signed [DW:0]   shade_sum;
    logic signed [SW-1:0] tx_w, ty_w, tz_w;
    logic                 clip;

    always_comb
    begin
        en            = !s2_valid_reg || q_ready;
        in_ready      = en;
        s1_valid_next = en ? in_valid : s1_valid_reg;
        s2_valid_next = en ? s1_valid_reg : s2_valid_reg;
        shade_sum     = $signed({shade_in[DW-1], shade_in}) + $signed(SHADE_BIAS);

        tx_w = SW'(px_reg[0]) + SW'(px_reg[1]) + SW'(px_reg[2])
             + SW'($signed(coef.xb[63:32]));
        ty_w = SW'(py_reg[0]) + SW'(py_reg[1]) + SW'(py_reg[2])
             + SW'($signed(coef.yb[63:32]));
        tz_w = SW'(pz_reg[0]) + SW'(pz_reg[1]) + SW'(pz_reg[2])
             + SW'($signed(coef.zb[63:32]));
        clip = !(tz_w > $signed(SW'(near_plane)));

        s2_item_next.tx      = sat32(tx_w);
        s2_item_next.ty      = sat32(ty_w);
        s2_item_next.clipped = clip;
        if (clip)
            s2_item_next.depth = near_plane;
        else if (|tz_w[SW-1:UW])
            s2_item_next.depth = MAX31;
        else
            s2_item_next.depth = tz_w[UW-1:0];
        s2_item_next.shade = s1_shade_reg;
        s2_item_next.last  = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0]    <= prod_shift(coef.xa[31:0],  pos_x);
            px_reg[1]    <= prod_shift(coef.xa[63:32], pos_y);
            px_reg[2]    <= prod_shift(coef.xb[31:0],  pos_z);
            py_reg[0]    <= prod_shift(coef.ya[31:0],  pos_x);
            py_reg[1]    <= prod_shift(coef.ya[63:32], pos_y);
            py_reg[2]    <= prod_shift(coef.yb[31:0],  pos_z);
            pz_reg[0]    <= prod_shift(coef.za[31:0],  pos_x);
            pz_reg[1]    <= prod_shift(coef.za[63:32], pos_y);
            pz_reg[2]    <= prod_shift(coef.zb[31:0],  pos_z);
            s1_shade_reg <= sat32(SW'(shade_sum));
            s1_last_reg  <= last_vertex;
            s2_item_reg  <= s2_item_next;
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_item  = s2_item_reg;

endmodule

FILE: rtl/pvp_queue.sv
// ----------------------------------------------------------------------------
// pvp_queue
// Short FIFO of view-space vertices between transform and projection.
// ----------------------------------------------------------------------------
module pvp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  pvp_pkg::view_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pvp_pkg::view_t pop_item
);
    import pvp_pkg::*;

    view_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             push, pop;

    always_comb
    begin
        push_ready  = count_reg != (QAW + 1)'(QDEPTH);
        pop_valid   = count_reg != '0;
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW + 1)'(push) - (QAW + 1)'(pop);
        pop_item    = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/pvp_back.sv
// ----------------------------------------------------------------------------
// pvp_back
// Inverse depth divider, screen multiply and scale by 1/704 and 1/448.
// ----------------------------------------------------------------------------
module pvp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  pvp_pkg::view_t         pop_item,
    input  logic [pvp_pkg::UW-1:0] screen_distance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pvp_pkg::proj_t         out_item
);
    import pvp_pkg::*;

    typedef struct packed {
        view_t         v;
        logic          sat;
        logic [UW-1:0] rem;
        logic [UW-1:0] quo;
        logic [UW-1:0] numlo;
    } div_t;

    typedef struct packed {
        logic signed [MW-1:0] px;
        logic signed [MW-1:0] py;
        logic [UW-1:0]        depth;
        logic [UW-1:0]        inv;
        logic                 clipped;
        logic signed [DW-1:0] shade;
        logic                 last;
    } mul_t;

    typedef struct packed {
        logic            neg_x;
        logic            neg_y;
        logic [LDW-1:0]  ax;
        logic [LDW-1:0]  ay;
        logic [LDW-1:0]  qx;
        logic [LDW-1:0]  qy;
        logic [RW-1:0]   rx;
        logic [RW-1:0]   ry;
        logic [UW-1:0]   depth;
        logic [UW-1:0]   inv;
        logic            clipped;
        logic signed [DW-1:0] shade;
        logic            last;
    } scl_t;

    function automatic div_t div_step(input div_t s);
        div_t      n;
        logic [UW:0] t;
        n     = s;
        t     = {s.rem, s.numlo[UW-1]};
        n.numlo = {s.numlo[UW-2:0], 1'b0};
        if (t >= {1'b0, s.v.depth})
        begin
            t     = t - {1'b0, s.v.depth};
            n.quo = {s.quo[UW-2:0], 1'b1};
        end
        else
        begin
            n.quo = {s.quo[UW-2:0], 1'b0};
        end
        n.rem = t[UW-1:0];
        return n;
    endfunction

    function automatic scl_t scl_step(input scl_t s);
        scl_t                  n;
        logic [LD_BITS+RW-1:0] rx_q;
        logic [LD_BITS+RW-1:0] ry_q;
        n    = s;
        rx_q = ld_step(s.rx, s.ax[LDW-1 -: LD_BITS], ODD_X);
        ry_q = ld_step(s.ry, s.ay[LDW-1 -: LD_BITS], ODD_Y);
        n.ax = s.ax << LD_BITS;
        n.ay = s.ay << LD_BITS;
        n.qx = {s.qx[LDW-LD_BITS-1:0], rx_q[LD_BITS+RW-1:RW]};
        n.qy = {s.qy[LDW-LD_BITS-1:0], ry_q[LD_BITS+RW-1:RW]};
        n.rx = rx_q[RW-1:0];
        n.ry = ry_q[RW-1:0];
        return n;
    endfunction

    function automatic logic signed [DW-1:0] fix_out(input logic neg,
                                                     input logic [LDW-1:0] q);
        if (|q[LDW-1:DW-1])
            return neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            return neg ? ~q[DW-1:0] : q[DW-1:0];
    endfunction

    logic              en;
    logic [UW:0]       dv_valid_reg;
    div_t              dv_reg [UW+1];
    div_t              dv0_next;
    logic [63:0]       num_w;
    logic              mu_valid_reg;
    mul_t              mu_reg, mu_next;
    logic [LD_STG:0]   cd_valid_reg;
    scl_t              cd_reg [LD_STG+1];
    scl_t              cd0_next;
    logic [MW-1:0]     ux, uy;
    logic              out_valid_reg;
    proj_t             out_reg, out_next;
    scl_t              cd_last;

    always_comb
    begin
        en        = !out_valid_reg || out_ready;
        pop_ready = en;

        // seed the divider; quotient overflow is a single compare
        num_w          = 64'(screen_distance) << FRAC_BITS;
        dv0_next.v     = pop_item;
        dv0_next.sat   = num_w >= (64'(pop_item.depth) << UW);
        dv0_next.rem   = num_w[2*UW-1:UW];
        dv0_next.numlo = num_w[UW-1:0];
        dv0_next.quo   = '0;

        mu_next.inv     = dv_reg[UW].sat ? MAX31 : dv_reg[UW].quo;
        mu_next.px      = $signed(MW'(dv_reg[UW].v.tx))
                        * $signed(MW'({1'b0, mu_next.inv}));
        mu_next.py      = $signed(MW'(dv_reg[UW].v.ty))
                        * $signed(MW'({1'b0, mu_next.inv}));
        mu_next.depth   = dv_reg[UW].v.depth;
        mu_next.clipped = dv_reg[UW].v.clipped;
        mu_next.shade   = dv_reg[UW].v.shade;
        mu_next.last    = dv_reg[UW].v.last;

        // floor division of negatives: fold through one's complement
        ux               = mu_reg.px[MW-1] ? ~mu_reg.px : mu_reg.px;
        uy               = mu_reg.py[MW-1] ? ~mu_reg.py : mu_reg.py;
        cd0_next.neg_x   = mu_reg.px[MW-1];
        cd0_next.neg_y   = mu_reg.py[MW-1];
        cd0_next.ax      = LDW'(ux >> SCALE_SHIFT);
        cd0_next.ay      = LDW'(uy >> SCALE_SHIFT);
        cd0_next.qx      = '0;
        cd0_next.qy      = '0;
        cd0_next.rx      = '0;
        cd0_next.ry      = '0;
        cd0_next.depth   = mu_reg.depth;
        cd0_next.inv     = mu_reg.inv;
        cd0_next.clipped = mu_reg.clipped;
        cd0_next.shade   = mu_reg.shade;
        cd0_next.last    = mu_reg.last;

        cd_last          = cd_reg[LD_STG];
        out_next.sx      = fix_out(cd_last.neg_x, cd_last.qx);
        out_next.sy      = fix_out(cd_last.neg_y, cd_last.qy);
        out_next.depth   = cd_last.depth;
        out_next.inv     = cd_last.inv;
        out_next.clipped = cd_last.clipped;
        out_next.shade   = cd_last.shade;
        out_next.last    = cd_last.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg  <= '0;
            mu_valid_reg  <= 1'b0;
            cd_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg  <= {dv_valid_reg[UW-1:0], pop_valid};
            mu_valid_reg  <= dv_valid_reg[UW];
            cd_valid_reg  <= {cd_valid_reg[LD_STG-1:0], mu_valid_reg};
            out_valid_reg <= cd_valid_reg[LD_STG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv0_next;
            mu_reg    <= mu_next;
            cd_reg[0] <= cd0_next;
            out_reg   <= out_next;
        end
    end

    for (genvar k = 0; k < UW; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k+1] <= div_step(dv_reg[k]);
        end
    end

    for (genvar j = 0; j < LD_STG; j++)
    begin : g_scale
        always_ff @(posedge clk)
        begin
            if (en)
                cd_reg[j+1] <= scl_step(cd_reg[j]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: rtl/perspective_vertex_project.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project
// Perspective projection of model vertices through a configured 3x4 matrix.
// ----------------------------------------------------------------------------
// Pipeline: an input beat reaches the output beat through
//   2 transform, 1 queue, 32 inverse-depth divider stages, 1 multiply,
//   6 scale stages and 1 output register.
// Throughput: one vertex per cycle unless out_ready stalls the output; the 4-entry
//   queue lets transform and projection stall independently.
// Reset: clears all valid state; matrix to zero, distance 188.0, near 188/32.
module perspective_vertex_project (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] shade_in,
    input  logic               last_vertex,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic [30:0]        depth,
    output logic [30:0]        inverse_depth,
    output logic               near_clipped,
    output logic signed [31:0] shade_out,
    output logic               last_out
);
    import pvp_pkg::*;

    coef_t         coef_reg;
    logic [UW-1:0] dist_reg;
    logic [UW-1:0] near_reg;
    logic          q_in_valid, q_in_ready;
    view_t         q_in_item;
    logic          q_out_valid, q_out_ready;
    view_t         q_out_item;
    proj_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            dist_reg <= SD_RESET;
            near_reg <= NEAR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_XA:   coef_reg.xa <= cfg_data;
                CFG_XB:   coef_reg.xb <= cfg_data;
                CFG_YA:   coef_reg.ya <= cfg_data;
                CFG_YB:   coef_reg.yb <= cfg_data;
                CFG_ZA:   coef_reg.za <= cfg_data;
                CFG_ZB:   coef_reg.zb <= cfg_data;
                CFG_DIST: dist_reg    <= cfg_data[UW-1:0];
                CFG_NEAR: near_reg    <= cfg_data[UW-1:0];
                default:  ;
            endcase
        end
    end

    pvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .shade_in   (shade_in),
        .last_vertex(last_vertex),
        .coef       (coef_reg),
        .near_plane (near_reg),
        .q_valid    (q_in_valid),
        .q_item     (q_in_item),
        .q_ready    (q_in_ready)
    );

    pvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(q_in_valid),
        .push_ready(q_in_ready),
        .push_item (q_in_item),
        .pop_valid (q_out_valid),
        .pop_ready (q_out_ready),
        .pop_item  (q_out_item)
    );

    pvp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (q_out_valid),
        .pop_ready      (q_out_ready),
        .pop_item       (q_out_item),
        .screen_distance(dist_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (res)
    );

    assign screen_x      = res.sx;
    assign screen_y      = res.sy;
    assign depth         = res.depth;
    assign inverse_depth = res.inv;
    assign near_clipped  = res.clipped;
    assign shade_out     = res.shade;
    assign last_out      = res.last;

endmodule
